/* sv/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants for the permutation cycle decomposer.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Width of an image and of an emitted element
  localparam int ELEM_W = 5;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_DUP   = 2'd2,
    ERR_FULL  = 2'd3
  } err_code_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_STEP,
    ST_REPORT
  } pcd_state_t;

endpackage

/* sv/pcd_image_ram.sv */
// ----------------------------------------------------------------------------
// pcd_image_ram
// Image table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcd_image_ram #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [pcd_pkg::ELEM_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [pcd_pkg::ELEM_W-1:0] rdata
);
  import pcd_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/permutation_cycle_decomposer_top.sv */
// ----------------------------------------------------------------------------
// permutation_cycle_decomposer_top
// Loads a permutation image by image, validates it and emits its cycles.
// ----------------------------------------------------------------------------
// While loading, the input is never stalled and every transfer is taken. After
// the final entry of n positions, validation reads the image RAM once per
// position in a pipelined sweep, then the cycle walk emits one element per
// cycle while the output is not stalled, with the start scan between cycles
// passing over positions already visited; the single read port of the image
// RAM with its registered read data sets that pace. Stalls on the output hold
// the walk. An error, also too many entries, gives a single result. Input is
// held off from the final entry until the last result of the run sits in the
// output register.
// ----------------------------------------------------------------------------
module permutation_cycle_decomposer_top #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pcd_pkg::ELEM_W-1:0] image,
  input  logic                       final_entry,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pcd_pkg::ELEM_W-1:0] element,
  output logic                       cycle_end,
  output logic                       run_last,
  output logic                       odd_parity,
  output logic [1:0]                 error_code
);
  import pcd_pkg::*;

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  pcd_state_t state, state_next;

  // run state
  logic [CW-1:0]           cnt;
  err_code_t               err_latch;
  logic                    parity;
  logic [MAX_ELEMENTS-1:0] taken;
  logic [MAX_ELEMENTS-1:0] visited;

  // validation sweep
  logic [CW-1:0] iss_idx;
  logic [CW-1:0] chk_cnt;
  logic          chk_pend;

  // cycle walk
  logic [IW-1:0] scan_i;
  logic [IW-1:0] start;
  logic [IW-1:0] cur_x;
  logic [CW-1:0] emit_cnt;
  logic          len_odd;

  // RAM interface
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  logic [ELEM_W-1:0] rd_data;
  logic [IW-1:0]     data_idx;

  // control terms
  logic accept, full, out_free;
  logic chk_eval, range_bad, dup_bad, chk_fail, chk_done;
  logic step_go, rep_go, close, is_last, out_load, run_done;

  pcd_image_ram #(
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[IW-1:0]),
    .wdata (image),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Control terms shared by next-state and datapath
  always_comb begin
    full      = (cnt == CW'(MAX_ELEMENTS));
    accept    = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    data_idx  = IW'(rd_data);
    chk_eval  = (state == ST_CHECK) && chk_pend;
    range_bad = (8'(rd_data) >= 8'(cnt));
    dup_bad   = taken[data_idx];
    chk_fail  = chk_eval && (range_bad || dup_bad);
    chk_done  = chk_eval && !range_bad && !dup_bad && (chk_cnt == cnt - CW'(1));
    close     = (data_idx == start);
    is_last   = (emit_cnt == cnt - CW'(1));
    step_go   = (state == ST_STEP) && out_free;
    rep_go    = (state == ST_REPORT) && out_free;
    out_load  = step_go || rep_go;
    run_done  = (step_go && close && is_last) || rep_go;
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = (state != ST_LOAD);
    ram_we    = in_valid && (state == ST_LOAD) && !full;
    ram_raddr = iss_idx[IW-1:0];
    unique case (state)
      ST_CHECK: ram_raddr = iss_idx[IW-1:0];
      ST_SCAN:  ram_raddr = scan_i;
      ST_STEP:  ram_raddr = (out_free && !close) ? data_idx : cur_x;
      default:  ram_raddr = iss_idx[IW-1:0];
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && final_entry) begin
          state_next = (full || err_latch != ERR_NONE) ? ST_REPORT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_fail) begin
          state_next = ST_REPORT;
        end else if (chk_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!visited[scan_i]) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step_go && close) begin
          state_next = is_last ? ST_LOAD : ST_SCAN;
        end
      end
      ST_REPORT: begin
        if (rep_go) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Run bookkeeping, validation and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      err_latch <= ERR_NONE;
      parity    <= 1'b0;
      taken     <= '0;
      visited   <= '0;
      chk_pend  <= 1'b0;
      iss_idx   <= '0;
      chk_cnt   <= '0;
      scan_i    <= '0;
      emit_cnt  <= '0;
      len_odd   <= 1'b0;
    end else begin
      // load
      if (accept) begin
        if (full) begin
          err_latch <= ERR_FULL;
        end else begin
          cnt <= cnt + CW'(1);
        end
        if (final_entry) begin
          iss_idx  <= '0;
          chk_cnt  <= '0;
          chk_pend <= 1'b0;
        end
      end

      // pipelined range and duplicate sweep
      if (state == ST_CHECK) begin
        chk_pend <= (iss_idx < cnt);
        if (iss_idx < cnt) begin
          iss_idx <= iss_idx + CW'(1);
        end
      end
      if (chk_eval) begin
        priority if (range_bad) begin
          err_latch <= ERR_RANGE;
        end else if (dup_bad) begin
          err_latch <= ERR_DUP;
        end else begin
          taken[data_idx] <= 1'b1;
          chk_cnt         <= chk_cnt + CW'(1);
        end
      end
      if (chk_done) begin
        scan_i   <= '0;
        emit_cnt <= '0;
        len_odd  <= 1'b0;
      end

      // find the lowest unvisited position
      if (state == ST_SCAN) begin
        if (visited[scan_i]) begin
          scan_i <= scan_i + IW'(1);
        end else begin
          start <= scan_i;
          cur_x <= scan_i;
        end
      end

      // walk one element per transfer; the last one leaves the marks to the clear
      if (step_go) begin
        emit_cnt <= emit_cnt + CW'(1);
        if (!run_done) begin
          visited[cur_x] <= 1'b1;
        end
        if (close) begin
          if (!run_done) begin
            parity <= parity ^ len_odd;
          end
          len_odd <= 1'b0;
          scan_i  <= scan_i + IW'(1);
        end else begin
          len_odd <= ~len_odd;
          cur_x   <= data_idx;
        end
      end

      // end of run: clear for the next permutation
      if (run_done) begin
        cnt       <= '0;
        err_latch <= ERR_NONE;
        parity    <= 1'b0;
        taken     <= '0;
        visited   <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      element    <= rep_go ? '0 : ELEM_W'(cur_x);
      cycle_end  <= step_go && close;
      run_last   <= rep_go || is_last;
      odd_parity <= step_go && is_last && (parity ^ len_odd);
      error_code <= rep_go ? err_latch : ERR_NONE;
    end
  end

endmodule

/* bench/permutation_cycle_decomposer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// permutation_cycle_decomposer_top_tb
// Self-checking bench for the permutation cycle decomposer. Permutations are
// loaded one image per transfer, and the emitted cycle elements, cycle ends,
// parity and error codes are compared against an in-bench cycle walker.
// Directed runs cover the small and error cases. Random runs cover valid,
// broken and oversized permutations under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module permutation_cycle_decomposer_top_tb;
  import pcd_pkg::*;

  localparam int PERM_MAX     = 32;
  localparam int PHASE_ITEMS  = 28;
  localparam int DRAIN_CYCLES = 2 * PERM_MAX + 16;
  localparam int REPORT_LIMIT = 10;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              cycle_end;
    logic              run_last;
    logic              odd_parity;
    err_code_t         error_code;
  } cycle_result_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [ELEM_W-1:0] image       = '0;
  logic              final_entry = 1'b0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [ELEM_W-1:0] element;
  logic              cycle_end;
  logic              run_last;
  logic              odd_parity;
  logic [1:0]        error_code;

  // Walker state: images of the permutation being loaded
  logic [ELEM_W-1:0] loaded_images [PERM_MAX];
  int                images_loaded = 0;
  err_code_t         load_fault    = ERR_NONE;
  cycle_result_t     cycle_results_due [$];

  logic [ELEM_W-1:0] run_buf [64];
  int                mismatch_count = 0;
  int                items_sent     = 0;
  int                send_idle_pct  = 35;
  int                stall_pct      = 87;

  permutation_cycle_decomposer_top #(
    .MAX_ELEMENTS(PERM_MAX)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .image      (image),
    .final_entry(final_entry),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .element    (element),
    .cycle_end  (cycle_end),
    .run_last   (run_last),
    .odd_parity (odd_parity),
    .error_code (error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Append one result to the expected queue
  function automatic void add_expected(cycle_result_t res);
    cycle_results_due.insert(cycle_results_due.size(), res);
  endfunction

  // Load one image; on the final one validate and walk the cycles
  function automatic void predict_cycles(logic [ELEM_W-1:0] img, logic fin);
    err_code_t         fault;
    logic [PERM_MAX-1:0] seen;
    int                n;
    int                x;
    int                nx;
    int                len;
    int                last;
    logic              odd;
    cycle_result_t     res;
    if (images_loaded >= PERM_MAX) begin
      load_fault = ERR_FULL;
    end else begin
      loaded_images[images_loaded] = img;
      images_loaded++;
    end
    if (!fin) return;
    n     = images_loaded;
    fault = load_fault;
    seen  = '0;
    // first bad position decides between range and duplicate
    if (fault == ERR_NONE) begin
      for (int i = 0; i < n; i++) begin
        x = int'(loaded_images[i]);
        if (x >= n) begin
          fault = ERR_RANGE;
          break;
        end
        if (seen[x]) begin
          fault = ERR_DUP;
          break;
        end
        seen[x] = 1'b1;
      end
    end
    if (fault != ERR_NONE) begin
      res.element    = '0;
      res.cycle_end  = 1'b0;
      res.run_last   = 1'b1;
      res.odd_parity = 1'b0;
      res.error_code = fault;
      add_expected(res);
    end else begin
      // each cycle starts at the lowest unvisited position
      seen = '0;
      odd  = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!seen[i]) begin
          x   = i;
          len = 0;
          do begin
            seen[x] = 1'b1;
            len++;
            nx             = int'(loaded_images[x]);
            res.element    = x[ELEM_W-1:0];
            res.cycle_end  = (nx == i);
            res.run_last   = 1'b0;
            res.odd_parity = 1'b0;
            res.error_code = ERR_NONE;
            add_expected(res);
            x = nx;
          end while (!seen[x]);
          if (len % 2 == 0) odd = ~odd;
        end
      end
      last = cycle_results_due.size() - 1;
      cycle_results_due[last].run_last   = 1'b1;
      cycle_results_due[last].odd_parity = odd;
    end
    images_loaded = 0;
    load_fault    = ERR_NONE;
  endfunction

  // One input transfer, with random idle cycles ahead of it
  task automatic send_image(input logic [ELEM_W-1:0] img, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    image       <= img;
    final_entry <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cycles(img, fin);
    items_sent++;
  endtask

  task automatic send_run(input int count);
    for (int i = 0; i < count; i++) begin
      send_image(run_buf[i], i == count - 1);
    end
  endtask

  // Random permutation of 0..n-1 in run_buf
  function automatic void fill_permutation(input int n);
    int                j;
    logic [ELEM_W-1:0] t;
    for (int i = 0; i < n; i++) run_buf[i] = i[ELEM_W-1:0];
    for (int i = n - 1; i > 0; i--) begin
      j          = $urandom_range(i, 0);
      t          = run_buf[i];
      run_buf[i] = run_buf[j];
      run_buf[j] = t;
    end
  endfunction

  // Mostly valid permutations, the rest broken in one of several ways
  task automatic send_random_run();
    int kind;
    int n;
    int pos;
    kind = $urandom_range(99);
    if (kind < 4) begin
      n = $urandom_range(PERM_MAX + 4, PERM_MAX + 1);
      for (int i = 0; i < n; i++) run_buf[i] = ELEM_W'($urandom_range(PERM_MAX - 1));
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(PERM_MAX, 9) : $urandom_range(8, 1);
      fill_permutation(n);
      if (kind < 14 && n < PERM_MAX) begin
        pos          = $urandom_range(n - 1);
        run_buf[pos] = ELEM_W'($urandom_range(PERM_MAX - 1, n));
      end else if (kind < 24 && n > 1) begin
        pos          = $urandom_range(n - 1, 1);
        run_buf[pos] = run_buf[$urandom_range(pos - 1)];
      end else if (kind < 29) begin
        for (int i = 0; i < n; i++) run_buf[i] = ELEM_W'($urandom_range(PERM_MAX - 1));
      end
    end
    send_run(n);
  endtask

  // One-position permutations: the fixed point and an out-of-range image
  task automatic test_single_position();
    send_image(5'd0, 1'b1);
    send_image(5'd31, 1'b1);
  endtask

  // Mixed cycle lengths (odd parity), then the identity (even parity)
  task automatic test_cycle_walk();
    send_image(5'd2, 1'b0);
    send_image(5'd0, 1'b0);
    send_image(5'd1, 1'b0);
    send_image(5'd4, 1'b0);
    send_image(5'd3, 1'b1);
    send_image(5'd0, 1'b0);
    send_image(5'd1, 1'b0);
    send_image(5'd2, 1'b1);
  endtask

  task automatic test_range_error();
    send_image(5'd0, 1'b0);
    send_image(5'd3, 1'b0);
    send_image(5'd1, 1'b1);
  endtask

  // Duplicates, and which error wins when both are present
  task automatic test_duplicate_error();
    send_image(5'd1, 1'b0);
    send_image(5'd1, 1'b0);
    send_image(5'd0, 1'b1);
    send_image(5'd0, 1'b0);
    send_image(5'd0, 1'b0);
    send_image(5'd7, 1'b1);
    send_image(5'd3, 1'b0);
    send_image(5'd1, 1'b0);
    send_image(5'd1, 1'b1);
  endtask

  task automatic test_full_permutation();
    fill_permutation(PERM_MAX);
    send_run(PERM_MAX);
  endtask

  // More entries than the block holds, with random images
  task automatic test_too_many_entries();
    for (int i = 0; i < PERM_MAX + 1; i++) run_buf[i] = ELEM_W'($urandom_range(PERM_MAX - 1));
    send_run(PERM_MAX + 1);
  endtask

  task automatic test_random_phase(input int idle_pct, input int hold_pct);
    int start;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    start         = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_random_run();
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each output transfer with the oldest expected result
  always @(posedge clk) begin : check_results
    cycle_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cycle_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: element=%0d cycle_end=%0b run_last=%0b odd=%0b err=%0d",
                   element, cycle_end, run_last, odd_parity, error_code);
      end else begin
        want = cycle_results_due.pop_front();
        if (element !== want.element || cycle_end !== want.cycle_end ||
            run_last !== want.run_last || odd_parity !== want.odd_parity ||
            error_code !== want.error_code) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected element=%0d cycle_end=%0b run_last=%0b odd=%0b err=%0d",
                     want.element, want.cycle_end, want.run_last, want.odd_parity,
                     want.error_code);
            $display("          got      element=%0d cycle_end=%0b run_last=%0b odd=%0b err=%0d",
                     element, cycle_end, run_last, odd_parity, error_code);
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_single_position();
    test_cycle_walk();
    test_range_error();
    test_duplicate_error();
    test_full_permutation();
    test_too_many_entries();
    test_random_phase(35, 87);
    test_random_phase(87, 35);
    test_random_phase(0, 0);
    in_valid <= 1'b0;
    while (cycle_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cycle_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
